>>> design/cc20_pkg.sv
// ChaCha20 stream unit: shared types, state constants and register codes.
// No dependencies; used by cc20_core and chacha20_stream_xor_unit.
package cc20_pkg;

	typedef logic [31:0] word_t;
	typedef logic [15:0][31:0] state_t;

	// "expand 32-byte k"
	localparam word_t CONST_W0 = 32'h6170_7865;
	localparam word_t CONST_W1 = 32'h3320_646e;
	localparam word_t CONST_W2 = 32'h7962_2d32;
	localparam word_t CONST_W3 = 32'h6b20_6574;

	localparam int NUM_ROUNDS = 20;
	localparam int ROUND_W    = $clog2(NUM_ROUNDS);

	// configuration register indexes
	localparam logic [2:0] CFG_KEY01   = 3'd0;
	localparam logic [2:0] CFG_KEY23   = 3'd1;
	localparam logic [2:0] CFG_KEY45   = 3'd2;
	localparam logic [2:0] CFG_KEY67   = 3'd3;
	localparam logic [2:0] CFG_NONCE01 = 3'd4;
	localparam logic [2:0] CFG_NONCE2  = 3'd5;

endpackage

>>> design/cc20_core.sv
// ChaCha20 block function: four quarter-round lanes, one add/xor/rotate step per cycle.
// Depends on cc20_pkg.
module cc20_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  cc20_pkg::state_t init,
	output logic             done,
	output cc20_pkg::state_t keystream
);

	cc20_pkg::state_t st_q;
	cc20_pkg::state_t init_q;
	cc20_pkg::state_t st_nxt;
	logic [1:0] step_q;
	logic [cc20_pkg::ROUND_W-1:0] rnd_q;
	logic run_q;
	logic fin_q;
	logic done_q;

	// step 0: a+=b, d^=a <<<16   step 1: c+=d, b^=c <<<12
	// step 2: a+=b, d^=a <<<8    step 3: c+=d, b^=c <<<7
	// odd rounds use the diagonals: row r of lane i is column (i+r) mod 4
	always_comb begin
		int sh;
		logic [3:0] ia, ib, ic, id;
		logic [3:0] ix, iy, iz;
		logic [31:0] xn, zx, zr;
		st_nxt = st_q;
		sh = rnd_q[0] ? 1 : 0;
		for (int i = 0; i < 4; i++) begin
			ia = 4'(i);
			ib = 4'(4 + ((i + sh) & 3));
			ic = 4'(8 + ((i + 2 * sh) & 3));
			id = 4'(12 + ((i + 3 * sh) & 3));
			if (step_q[0]) begin
				ix = ic; iy = id; iz = ib;
			end else begin
				ix = ia; iy = ib; iz = id;
			end
			xn = st_q[ix] + st_q[iy];
			zx = st_q[iz] ^ xn;
			case (step_q)
				2'd0:    zr = {zx[15:0], zx[31:16]};
				2'd1:    zr = {zx[19:0], zx[31:20]};
				2'd2:    zr = {zx[23:0], zx[31:24]};
				default: zr = {zx[24:0], zx[31:25]};
			endcase
			st_nxt[ix] = xn;
			st_nxt[iz] = zr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			rnd_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
				rnd_q  <= '0;
			end else if (run_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					if (rnd_q == cc20_pkg::ROUND_W'(cc20_pkg::NUM_ROUNDS - 1)) begin
						run_q <= 1'b0;
						fin_q <= 1'b1;
					end else begin
						rnd_q <= rnd_q + cc20_pkg::ROUND_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			st_q   <= init;
			init_q <= init;
		end else if (run_q) begin
			st_q <= st_nxt;
		end else if (fin_q) begin
			// feed-forward of the input state
			for (int i = 0; i < 16; i++)
				st_q[i] <= st_q[i] + init_q[i];
		end
	end

	assign done      = done_q;
	assign keystream = st_q;

endmodule

>>> design/chacha20_stream_xor_unit.sv
// ChaCha20 stream encrypt/decrypt unit, top level.
// Depends on cc20_pkg and cc20_core.
//
// Usage:
//  - Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) loads key and nonce:
//    index 0..3 key word pairs (even word low), 4 nonce words 0/1, 5 nonce word 2
//    (cfg_data[31:0]); other indexes are dropped. cfg_ready is always high. Write
//    only while idle; a new key/nonce is picked up by the next keystream block.
//  - s_axis_*: one 32-bit little-endian data word per item, tlast marks the last
//    word of a message. m_axis_*: data XOR keystream, tlast copied.
//  - The first word of each 64-byte block starts the block function: round steps
//    (four quarter-round lanes, one add/xor/rotate step each per cycle) plus the
//    feed-forward add; that word goes out once the block function is done. The
//    other 15 words go out in the cycle after they are taken. No new word is taken
//    while the block function runs; the shared round-step datapath limits throughput.
//  - The block counter starts at 0, counts blocks and wraps at 2^32. After a tlast
//    word the counter and the word position return to 0.
//  - Reset (arst_n low) clears key, nonce, counter, position and output valid.
//  - A single output register holds the result; while it is full and m_axis_tready
//    is low, s_axis_tready stays low. No item is dropped.
module chacha20_stream_xor_unit (
	input  logic        clk,
	input  logic        arst_n,
	// config write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] data_word
	input  logic        s_axis_tlast,   // message_last
	// output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] cipher_word
	output logic        m_axis_tlast    // result_last
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_GEN  = 1'b1;

	logic [3:0][63:0] key_q;
	logic [63:0] nonce01_q;
	logic [31:0] nonce2_q;

	logic        state_q;
	logic [3:0]  pos_q;
	logic [31:0] ctr_q;
	logic [31:0] data_q;
	logic        last_q;
	logic        out_valid_q;
	logic [31:0] out_data_q;
	logic        out_last_q;

	logic in_acc;
	logic out_set;
	logic core_start;
	logic core_done;
	cc20_pkg::state_t core_init;
	cc20_pkg::state_t ks;

	assign cfg_ready = 1'b1;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q     <= '0;
			nonce01_q <= '0;
			nonce2_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				cc20_pkg::CFG_KEY01:   key_q[0]  <= cfg_data;
				cc20_pkg::CFG_KEY23:   key_q[1]  <= cfg_data;
				cc20_pkg::CFG_KEY45:   key_q[2]  <= cfg_data;
				cc20_pkg::CFG_KEY67:   key_q[3]  <= cfg_data;
				cc20_pkg::CFG_NONCE01: nonce01_q <= cfg_data;
				cc20_pkg::CFG_NONCE2:  nonce2_q  <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// initial block state: constants, key, counter, nonce
	always_comb begin
		core_init[0] = cc20_pkg::CONST_W0;
		core_init[1] = cc20_pkg::CONST_W1;
		core_init[2] = cc20_pkg::CONST_W2;
		core_init[3] = cc20_pkg::CONST_W3;
		for (int i = 0; i < 4; i++) begin
			core_init[4 + 2 * i] = key_q[i][31:0];
			core_init[5 + 2 * i] = key_q[i][63:32];
		end
		core_init[12] = ctr_q;
		core_init[13] = nonce01_q[31:0];
		core_init[14] = nonce01_q[63:32];
		core_init[15] = nonce2_q;
	end

	// take an item only when idle and the output register is free or draining
	assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign core_start    = in_acc && (pos_q == 4'd0);

	// a result lands in the output register: mid-block word, or word 0 after the rounds
	assign out_set = ((state_q == ST_IDLE) && in_acc && (pos_q != 4'd0)) ||
		((state_q == ST_GEN) && core_done);

	cc20_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (core_start),
		.init      (core_init),
		.done      (core_done),
		.keystream (ks)
	);

	// control: position, counter, sequencer, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			ctr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_set)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						pos_q <= s_axis_tlast ? 4'd0 : pos_q + 4'd1;
						if (pos_q == 4'd0) begin
							state_q <= ST_GEN;
						end else begin
							if (s_axis_tlast)
								ctr_q <= '0;
						end
					end
				end
				ST_GEN: begin
					if (core_done) begin
						state_q <= ST_IDLE;
						ctr_q   <= last_q ? 32'd0 : ctr_q + 32'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			data_q <= s_axis_tdata;
			last_q <= s_axis_tlast;
			if (pos_q != 4'd0) begin
				out_data_q <= s_axis_tdata ^ ks[pos_q];
				out_last_q <= s_axis_tlast;
			end
		end else if (state_q == ST_GEN && core_done) begin
			out_data_q <= data_q ^ ks[0];
			out_last_q <= last_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

endmodule

>>> bench/testbench.sv
// Self-checking bench for chacha20_stream_xor_unit: streams key/nonce settings and data words,
// predicts each cipher word (in-bench block function or directed row) and checks the output.
// Depends on cc20_pkg (types, register indexes) and the unit's RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT_CYCLES = 1_000_000;
	localparam int DRAIN_CYCLES = 120;     // > one block-function latency
	localparam int HOLD_CYCLES  = 400;     // long output stall, forces input backpressure
	localparam int HOLD_AFTER   = 150;     // results seen before the long stall starts
	localparam int PHASES       = 9;
	localparam int PHASE_ITEMS  = 56;
	localparam int DIR_ROWS     = 24;

	// indexes past the register file; writes there must be dropped
	localparam logic [2:0] CFG_SPARE6 = 3'd6;
	localparam logic [2:0] CFG_SPARE7 = 3'd7;
	localparam logic [2:0] CFG_REGS [6] = '{cc20_pkg::CFG_KEY01, cc20_pkg::CFG_KEY23,
		cc20_pkg::CFG_KEY45, cc20_pkg::CFG_KEY67, cc20_pkg::CFG_NONCE01,
		cc20_pkg::CFG_NONCE2};

	// "expand 32-byte k", kept local so a bad package constant gets caught
	localparam cc20_pkg::word_t SIGMA [4] = '{32'h6170_7865, 32'h3320_646e, 32'h7962_2d32,
		32'h6b20_6574};

	typedef struct packed {
		cc20_pkg::word_t cipher;
		logic            last;
	} cipher_item_t;

	typedef struct packed {
		cc20_pkg::word_t data;
		logic            last;
		logic            known;   // want holds the cipher word to expect
		cc20_pkg::word_t want;
	} dir_row_t;

	typedef enum logic [1:0] {RX_STEADY, RX_LIGHT, RX_HEAVY, RX_BURSTY} rx_mode_t;

	// Directed words, sent right after reset (all-zero key and nonce). Zero data then shows
	// the raw keystream of the all-zero key: block 0 starts 0xade0b876, 0x903df1a0.
	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		'{32'h0000_0000, 1'b0, 1'b1, 32'hade0_b876},  // position 0, counter 0
		'{32'h0000_0000, 1'b0, 1'b1, 32'h903d_f1a0},
		'{32'hffff_ffff, 1'b0, 1'b0, 32'h0},
		'{32'h8000_0000, 1'b0, 1'b0, 32'h0},
		'{32'h0000_0001, 1'b1, 1'b0, 32'h0},          // message ends mid-block
		'{32'h0000_0000, 1'b1, 1'b1, 32'hade0_b876},  // one-word message, counter back at 0
		'{32'h0000_0000, 1'b0, 1'b1, 32'hade0_b876},  // full block follows
		'{32'h0000_ffff, 1'b0, 1'b0, 32'h0},
		'{32'hffff_0000, 1'b0, 1'b0, 32'h0},
		'{32'ha5a5_a5a5, 1'b0, 1'b0, 32'h0},
		'{32'h5a5a_5a5a, 1'b0, 1'b0, 32'h0},
		'{32'h0f0f_0f0f, 1'b0, 1'b0, 32'h0},
		'{32'hf0f0_f0f0, 1'b0, 1'b0, 32'h0},
		'{32'h1234_5678, 1'b0, 1'b0, 32'h0},
		'{32'h8765_4321, 1'b0, 1'b0, 32'h0},
		'{32'h0000_0001, 1'b0, 1'b0, 32'h0},
		'{32'h7fff_ffff, 1'b0, 1'b0, 32'h0},
		'{32'h3333_cccc, 1'b0, 1'b0, 32'h0},
		'{32'hcccc_3333, 1'b0, 1'b0, 32'h0},
		'{32'h0101_0101, 1'b0, 1'b0, 32'h0},
		'{32'hfefe_fefe, 1'b0, 1'b0, 32'h0},
		'{32'hffff_ffff, 1'b0, 1'b0, 32'h0},          // position 15
		'{32'h0000_0000, 1'b0, 1'b0, 32'h0},          // block counter 1
		'{32'hffff_ffff, 1'b1, 1'b0, 32'h0}
	};

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;   // [31:0] data_word
	logic        s_axis_tlast;   // message_last
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;   // [31:0] cipher_word
	logic        m_axis_tlast;   // result_last

	// cipher model state
	logic [63:0]     cfg_shadow [6];
	cc20_pkg::word_t blk_ctr;
	logic [3:0]      word_pos;
	cc20_pkg::word_t ks_words [16];
	cc20_pkg::word_t mix_st [16];

	cipher_item_t cipher_q [$];
	int errors       = 0;
	int results_seen = 0;
	int cycle_count  = 0;
	int burst_left   = 0;
	int msg_left     = 0;

	chacha20_stream_xor_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------- cipher model ----------------

	function automatic cc20_pkg::word_t rotl(cc20_pkg::word_t v, int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic void quarter_round(int a, int b, int c, int d);
		mix_st[a] = mix_st[a] + mix_st[b]; mix_st[d] = rotl(mix_st[d] ^ mix_st[a], 16);
		mix_st[c] = mix_st[c] + mix_st[d]; mix_st[b] = rotl(mix_st[b] ^ mix_st[c], 12);
		mix_st[a] = mix_st[a] + mix_st[b]; mix_st[d] = rotl(mix_st[d] ^ mix_st[a], 8);
		mix_st[c] = mix_st[c] + mix_st[d]; mix_st[b] = rotl(mix_st[b] ^ mix_st[c], 7);
	endfunction

	// 20 rounds over constants | key | counter | nonce, then the feed-forward add
	function automatic void refresh_keystream();
		cc20_pkg::word_t init_st [16];
		for (int i = 0; i < 4; i++) begin
			init_st[i]         = SIGMA[i];
			init_st[4 + 2 * i] = cfg_shadow[i][31:0];
			init_st[5 + 2 * i] = cfg_shadow[i][63:32];
		end
		init_st[12] = blk_ctr;
		init_st[13] = cfg_shadow[4][31:0];
		init_st[14] = cfg_shadow[4][63:32];
		init_st[15] = cfg_shadow[5][31:0];
		mix_st = init_st;
		for (int r = 0; r < 10; r++) begin
			quarter_round(0, 4, 8, 12);
			quarter_round(1, 5, 9, 13);
			quarter_round(2, 6, 10, 14);
			quarter_round(3, 7, 11, 15);
			quarter_round(0, 5, 10, 15);
			quarter_round(1, 6, 11, 12);
			quarter_round(2, 7, 8, 13);
			quarter_round(3, 4, 9, 14);
		end
		for (int i = 0; i < 16; i++)
			ks_words[i] = mix_st[i] + init_st[i];
	endfunction

	// A new keystream block is made only at position 0, so key/nonce changes made
	// mid-block apply from the next block on. A block counter wrap needs 2^32 blocks
	// and is out of reach of any run.
	function automatic cipher_item_t encrypt_word(cc20_pkg::word_t data, logic last);
		cipher_item_t res;
		if (word_pos == 4'd0) begin
			refresh_keystream();
			blk_ctr = blk_ctr + 32'd1;
		end
		res.cipher = data ^ ks_words[word_pos];
		res.last   = last;
		if (last) begin
			blk_ctr  = '0;
			word_pos = '0;
		end else begin
			word_pos = word_pos + 4'd1;
		end
		return res;
	endfunction

	function automatic void shadow_write(logic [2:0] idx, logic [63:0] val);
		case (idx)
			cc20_pkg::CFG_KEY01, cc20_pkg::CFG_KEY23, cc20_pkg::CFG_KEY45,
			cc20_pkg::CFG_KEY67, cc20_pkg::CFG_NONCE01: begin
				cfg_shadow[idx] = val;
			end
			cc20_pkg::CFG_NONCE2: begin
				cfg_shadow[5] = {32'd0, val[31:0]};
			end
			default: begin
			end
		endcase
	endfunction

	// ---------------- input side ----------------

	task automatic send_word(cc20_pkg::word_t data, logic last, logic known,
		cc20_pkg::word_t want);
		cipher_item_t exp_item;
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = data;
		s_axis_tlast  = last;
		do @(posedge clk); while (!s_axis_tready);
		exp_item = encrypt_word(data, last);
		if (known)
			exp_item.cipher = want;
		cipher_q.push_back(exp_item);
	endtask

	// valid low with junk on the data lines, for an idle gap set by n
	task automatic idle_for(int n);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = $urandom;
		s_axis_tlast  = 1'($urandom_range(0, 1));
		repeat (n - 1) @(negedge clk);
	endtask

	// bursts of random length, some long enough to run without any gap
	task automatic pace_sender();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			idle_for($urandom_range(1, 12));
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 90)
				: $urandom_range(0, 20);
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (cipher_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		do @(posedge clk); while (!cfg_ready);
		shadow_write(idx, val);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// first phase all ones, last phase all zeros, random subsets in between; sometimes a spare-index write too
	task automatic reconfigure(int phase);
		for (int i = 0; i < 6; i++) begin
			if (phase == 0)
				write_reg(CFG_REGS[i], '1);
			else if (phase == PHASES - 1)
				write_reg(CFG_REGS[i], '0);
			else if ($urandom_range(0, 1) == 1)
				write_reg(CFG_REGS[i], {$urandom, $urandom});
		end
		if ($urandom_range(0, 2) == 0)
			write_reg($urandom_range(0, 1) ? CFG_SPARE6 : CFG_SPARE7, {$urandom, $urandom});
	endtask

	// mostly short messages, some spanning a few blocks
	function automatic int pick_msg_len();
		int r;
		r = $urandom_range(0, 19);
		if (r < 13)
			return $urandom_range(1, 20);
		else if (r < 19)
			return $urandom_range(17, 48);
		return $urandom_range(60, 100);
	endfunction

	initial begin
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		blk_ctr       = '0;
		word_pos      = '0;
		for (int i = 0; i < 6; i++)
			cfg_shadow[i] = '0;
		for (int i = 0; i < 16; i++) begin
			ks_words[i] = '0;
			mix_st[i]   = '0;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < DIR_ROWS; i++) begin
			send_word(DIRECTED[i].data, DIRECTED[i].last, DIRECTED[i].known, DIRECTED[i].want);
			pace_sender();
		end

		// Phases stop at an arbitrary item, often inside a message and inside a block,
		// so new settings also land mid-block.
		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			reconfigure(p);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (msg_left == 0)
					msg_left = pick_msg_len();
				send_word($urandom, msg_left == 1, 1'b0, '0);
				msg_left--;
				pace_sender();
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("chacha20_stream_xor_unit regression: pass");
		else
			$display("chacha20_stream_xor_unit regression: fail");
		$finish;
	end

	// ---------------- output side ----------------

	initial begin
		rx_mode_t mode;
		int seg_left;
		int stall_left;
		bit hold_done;
		mode          = RX_STEADY;
		seg_left      = 0;
		stall_left    = 0;
		hold_done     = 1'b0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_done && results_seen >= HOLD_AFTER) begin
				// output register fills, input must stall while the sender keeps offering
				hold_done     = 1'b1;
				m_axis_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if (seg_left == 0) begin
				mode     = rx_mode_t'($urandom_range(0, 3));
				seg_left = $urandom_range(20, 120);
			end
			seg_left--;
			case (mode)
				RX_STEADY: m_axis_tready = 1'b1;
				RX_LIGHT:  m_axis_tready = ($urandom_range(0, 3) != 0);
				RX_HEAVY:  m_axis_tready = ($urandom_range(0, 3) == 0);
				default: begin
					if (stall_left > 0) begin
						m_axis_tready = 1'b0;
						stall_left--;
					end else begin
						m_axis_tready = 1'b1;
						if ($urandom_range(0, 15) == 0)
							stall_left = $urandom_range(5, 30);
					end
				end
			endcase
		end
	end

	always @(posedge clk) begin : check_results
		cipher_item_t exp_item;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (cipher_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected item: expected none, got cipher %h last %b",
					$time, m_axis_tdata, m_axis_tlast);
			end else begin
				exp_item = cipher_q.pop_front();
				if (m_axis_tdata !== exp_item.cipher) begin
					errors++;
					$display("%0t: cipher_word mismatch: expected %h, got %h",
						$time, exp_item.cipher, m_axis_tdata);
				end
				if (m_axis_tlast !== exp_item.last) begin
					errors++;
					$display("%0t: result_last mismatch: expected %b, got %b",
						$time, exp_item.last, m_axis_tlast);
				end
			end
		end
	end

	// watchdog
	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: timeout after %0d cycles, %0d items outstanding",
			$time, cycle_count, cipher_q.size());
		$display("chacha20_stream_xor_unit regression: fail");
		$finish;
	end

endmodule
